// File: rtl/core/dscps_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the driven spin chain block.
// No dependencies; every other file imports this package.
package dscps_pkg;

    localparam int MAX_SPINS    = 128;
    localparam int CORDIC_STEPS = 24;

    localparam int SPIN_AW = $clog2(MAX_SPINS);
    localparam int NW      = $clog2(MAX_SPINS + 1);
    localparam int ITER_W  = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    // Shared multiplier operand and product widths.
    localparam int MA_W = 41;
    localparam int MB_W = 33;
    localparam int MP_W = MA_W + MB_W;

    // CORDIC datapath and residual angle widths.
    localparam int CW = 36;
    localparam int RW = 34;

    localparam int ACC_W = 56;

    localparam int S_DATA_W = 104;
    localparam int M_DATA_W = 144;

    // Converts P >> 24 (Q16.24 radians) into a half angle in 2^-32 turn units.
    localparam logic [28:0] ANGLE_K = 29'd341782638;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_STEP = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    localparam logic KIND_ENERGY = 1'b0;
    localparam logic KIND_SPIN   = 1'b1;

    localparam logic [2:0] REG_COUPLING = 3'd0;
    localparam logic [2:0] REG_FIELD_Z  = 3'd1;
    localparam logic [2:0] REG_FIELD_X  = 3'd2;
    localparam logic [2:0] REG_PERIOD   = 3'd3;
    localparam logic [2:0] REG_CHAIN    = 3'd4;

    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic busy;
        logic done;
    } cordic_stat_t;

    // Largest Q0.31 factor whose square times the squared CORDIC gain stays at or below one.
    function automatic logic [31:0] gain_comp_f();
        longint unsigned k;
        longint unsigned c;
        longint unsigned t;
        k = 64'd1 << 60;
        c = 64'd0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            k = k + (k >> (2 * i));
        end
        k = k >> 30;
        for (int b = 30; b >= 0; b--)
        begin
            t = c | (64'd1 << b);
            if ((((t * t) >> 31) * k) <= (64'd1 << 61))
            begin
                c = t;
            end
        end
        return c[31:0];
    endfunction

    localparam logic [31:0] GAIN_COMP = gain_comp_f();

    function automatic logic signed [31:0] sat32(input logic signed [MP_W-1:0] v);
        logic signed [31:0] r;
        if ((&v[MP_W-1:31]) || !(|v[MP_W-1:31]))
        begin
            r = v[31:0];
        end
        else
        begin
            r = v[MP_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [ACC_W-1:0] v);
        logic signed [47:0] r;
        if ((&v[ACC_W-1:47]) || !(|v[ACC_W-1:47]))
        begin
            r = v[47:0];
        end
        else
        begin
            r = v[ACC_W-1] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
        return r;
    endfunction

endpackage

// File: rtl/core/dscps_mul.sv
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
// Depends on dscps_pkg for operand widths.
module dscps_mul
    import dscps_pkg::*;
(
    input  logic                   clk,
    input  logic signed [MA_W-1:0] op_a,
    input  logic signed [MB_W-1:0] op_b,
    output logic signed [MP_W-1:0] prod
);

    logic signed [MP_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= MP_W'(op_a) * MP_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

// File: rtl/core/dscps_cordic.sv
`timescale 1ns / 1ps
// Iterative CORDIC rotator, one micro-rotation per clock, gain left uncompensated.
// Depends on dscps_pkg for widths, the arctangent table and the status struct.
module dscps_cordic
    import dscps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [31:0]   a0,
    input  logic signed [31:0]   b0,
    input  logic [31:0]          angle,
    output logic signed [CW-1:0] a,
    output logic signed [CW-1:0] b,
    output cordic_stat_t         stat
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [ITER_W-1:0]    it_reg;
    logic signed [CW-1:0] a_reg;
    logic signed [CW-1:0] b_reg;
    logic signed [RW-1:0] r_reg;

    logic                 flip;
    logic [31:0]          t_in;
    logic signed [CW-1:0] a_in;
    logic signed [CW-1:0] b_in;
    logic signed [CW-1:0] da;
    logic signed [CW-1:0] db;
    logic signed [RW-1:0] atan_v;
    logic signed [CW-1:0] a_next;
    logic signed [CW-1:0] b_next;
    logic signed [RW-1:0] r_next;
    logic [31:0]          tsum;

    // Angles in the left half plane are folded by a half turn first.
    always_comb
    begin
        tsum = angle + 32'h4000_0000;
        flip = tsum[31];
        t_in = flip ? (angle + 32'h8000_0000) : angle;
        a_in = flip ? -CW'(a0) : CW'(a0);
        b_in = flip ? -CW'(b0) : CW'(b0);
    end

    always_comb
    begin
        da     = b_reg >>> it_reg;
        db     = a_reg >>> it_reg;
        atan_v = RW'(signed'({1'b0, ATAN_TURNS[5'(it_reg)]}));
        if (!r_reg[RW-1])
        begin
            a_next = a_reg - da;
            b_next = b_reg + db;
            r_next = r_reg - atan_v;
        end
        else
        begin
            a_next = a_reg + da;
            b_next = b_reg - db;
            r_next = r_reg + atan_v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                it_reg   <= '0;
            end
            else if (busy_reg)
            begin
                it_reg <= it_reg + ITER_W'(1);
                if (it_reg == ITER_W'(CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a_in;
            b_reg <= b_in;
            r_reg <= RW'(signed'(t_in));
        end
        else if (busy_reg)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            r_reg <= r_next;
        end
    end

    assign a         = a_reg;
    assign b         = b_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: rtl/core/driven_spin_chain_period_step.sv
`timescale 1ns / 1ps
// Top level of the driven spin ring: spin store, sequencer and shared units.
// Depends on dscps_pkg, dscps_mul and dscps_cordic.
//
//  Channel   Dir  Handshake                 Payload
//  s_axis    in   s_tvalid / s_tready       s_tuser mode, s_tdata spin fields
//  m_axis    out  m_tvalid / m_tready       m_tuser kind, m_tdata energy, spin
//  cfg       in   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A load word writes the spin store when accepted and gives no result; a read word's
// result passes through the store's read register and then the output register.
// A step word walks every spin of the ring in turn, paced by the single CORDIC rotator
// and the one multiplier that every product of the step goes through.
// Input is not taken while a word is being worked on; a finished result waits in the
// output register, and the sequencer holds in its last state while that is still full.
// Reset clears control and loads the configuration defaults; the spin store is undefined until loaded.
module driven_spin_chain_period_step
    import dscps_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // spin_index[6:0], spin_x[38:7], spin_y[70:39], spin_z[102:71], zero pad
    input  logic [S_DATA_W-1:0] s_tdata,
    // mode[1:0]
    input  logic [1:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // energy[47:0], read_x[79:48], read_y[111:80], read_z[143:112]
    output logic [M_DATA_W-1:0] m_tdata,
    // result_kind[0]
    output logic [0:0]          m_tuser,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_OUT  = 5'd1;
    localparam logic [4:0] T_AX0  = 5'd2;
    localparam logic [4:0] T_AX1  = 5'd3;
    localparam logic [4:0] T_AX2  = 5'd4;
    localparam logic [4:0] T_RC   = 5'd5;
    localparam logic [4:0] T_RN   = 5'd6;
    localparam logic [4:0] T_K0   = 5'd7;
    localparam logic [4:0] T_K1   = 5'd8;
    localparam logic [4:0] T_K2   = 5'd9;
    localparam logic [4:0] T_K3   = 5'd10;
    localparam logic [4:0] T_K4   = 5'd11;
    localparam logic [4:0] T_K5   = 5'd12;
    localparam logic [4:0] T_C1   = 5'd13;
    localparam logic [4:0] T_G1   = 5'd14;
    localparam logic [4:0] T_G2   = 5'd15;
    localparam logic [4:0] T_C2   = 5'd16;
    localparam logic [4:0] T_G3   = 5'd17;
    localparam logic [4:0] T_G4   = 5'd18;
    localparam logic [4:0] E_RC   = 5'd19;
    localparam logic [4:0] E_RN   = 5'd20;
    localparam logic [4:0] E_M0   = 5'd21;
    localparam logic [4:0] E_M1   = 5'd22;
    localparam logic [4:0] E_M2   = 5'd23;
    localparam logic [4:0] E_M3   = 5'd24;
    localparam logic [4:0] E_M4   = 5'd25;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    logic signed [31:0] coupling_reg;
    logic signed [31:0] field_z_reg;
    logic signed [31:0] field_x_reg;
    logic [30:0]        period_reg;
    logic [7:0]         chain_len_reg;

    logic [NW-1:0] n_reg;
    logic [NW-1:0] j_reg;
    logic [NW-1:0] ring_n;
    logic [NW-1:0] nxt_j;
    logic          has_next;
    logic          kind_reg;

    logic [95:0] spin_mem [MAX_SPINS];
    logic [95:0] rd_data_reg;
    logic        rd_en;
    logic [SPIN_AW-1:0] rd_addr;
    logic        wr_en;
    logic [SPIN_AW-1:0] wr_addr;
    logic [95:0] wr_data;
    logic signed [31:0] rd_x;
    logic signed [31:0] rd_y;
    logic signed [31:0] rd_z;

    logic signed [31:0] cur_x_reg;
    logic signed [31:0] cur_y_reg;
    logic signed [31:0] cur_z_reg;
    logic signed [31:0] first_z_reg;
    logic signed [31:0] prev_z_reg;
    logic signed [31:0] nz_reg;
    logic signed [34:0] kacc_reg;
    logic signed [31:0] kappa_reg;
    logic [31:0]        ax_reg;
    logic signed [31:0] new_x_reg;
    logic signed [31:0] new_y_reg;
    logic signed [ACC_W-1:0] acc_reg;

    logic signed [MA_W-1:0] op_a;
    logic signed [MB_W-1:0] op_b;
    logic signed [MP_W-1:0] prod;
    logic signed [MP_W-1:0] prod_sh24;
    logic signed [MP_W-1:0] prod_sh30;
    logic signed [MP_W-1:0] prod_sh31;
    logic signed [31:0]     prod_sat;
    logic signed [35:0]     ksum;
    logic signed [MB_W-1:0] period_op;
    logic signed [MB_W-1:0] angle_k_op;
    logic signed [MB_W-1:0] comp_op;

    logic                 c_start;
    logic signed [31:0]   c_a0;
    logic signed [31:0]   c_b0;
    logic [31:0]          c_angle;
    logic signed [CW-1:0] c_a;
    logic signed [CW-1:0] c_b;
    cordic_stat_t         c_stat;

    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic                m_tuser_reg;
    logic                s_acc;
    logic                out_load;
    logic signed [ACC_W-1:0] acc_half;

    dscps_mul u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    dscps_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (c_start),
        .a0    (c_a0),
        .b0    (c_b0),
        .angle (c_angle),
        .a     (c_a),
        .b     (c_b),
        .stat  (c_stat)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    assign rd_x = rd_data_reg[31:0];
    assign rd_y = rd_data_reg[63:32];
    assign rd_z = rd_data_reg[95:64];

    assign nxt_j     = j_reg + NW'(1);
    assign has_next  = (nxt_j < n_reg);
    assign prod_sh24 = prod >>> 24;
    assign prod_sh30 = prod >>> 30;
    assign prod_sh31 = prod >>> 31;
    assign prod_sat  = sat32(prod_sh31);
    assign ksum      = 36'(kacc_reg) + 36'(signed'(prod_sh30[34:0])) + 36'(field_z_reg);
    assign acc_half  = acc_reg >>> 1;

    assign period_op  = MB_W'(signed'({1'b0, period_reg}));
    assign angle_k_op = MB_W'(signed'({1'b0, ANGLE_K}));
    assign comp_op    = MB_W'(signed'({1'b0, GAIN_COMP}));

    always_comb
    begin
        if (32'(chain_len_reg) < 32'd2)
        begin
            ring_n = NW'(2);
        end
        else if (32'(chain_len_reg) > 32'(MAX_SPINS))
        begin
            ring_n = NW'(MAX_SPINS);
        end
        else
        begin
            ring_n = NW'(chain_len_reg);
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coupling_reg  <= 32'sd16777216;
            field_z_reg   <= 32'sd11819745;
            field_x_reg   <= 32'sd13572571;
            period_reg    <= 31'd27750626;
            chain_len_reg <= 8'd100;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_COUPLING: coupling_reg  <= cfg_data;
                REG_FIELD_Z:  field_z_reg   <= cfg_data;
                REG_FIELD_X:  field_x_reg   <= cfg_data;
                REG_PERIOD:   period_reg    <= cfg_data[30:0];
                REG_CHAIN:    chain_len_reg <= cfg_data[7:0];
                default:      ;
            endcase
        end
    end

    // Spin store, one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            spin_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= spin_mem[rd_addr];
        end
    end

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = j_reg[SPIN_AW-1:0];
        wr_en   = 1'b0;
        wr_addr = j_reg[SPIN_AW-1:0];
        wr_data = {prod_sat, new_y_reg, new_x_reg};
        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = s_tdata[SPIN_AW-1:0];
                wr_addr = s_tdata[SPIN_AW-1:0];
                wr_data = s_tdata[102:7];
                rd_en   = s_acc && (s_tuser == MODE_READ);
                wr_en   = s_acc && (s_tuser == MODE_LOAD);
            end
            T_AX0:
            begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            T_AX1:
            begin
                rd_en   = 1'b1;
                rd_addr = SPIN_AW'(n_reg - NW'(1));
            end
            T_RC, E_RC:
            begin
                rd_en = 1'b1;
            end
            T_RN:
            begin
                rd_en   = has_next;
                rd_addr = nxt_j[SPIN_AW-1:0];
            end
            E_RN:
            begin
                rd_en   = 1'b1;
                rd_addr = has_next ? nxt_j[SPIN_AW-1:0] : '0;
            end
            T_G4:
            begin
                wr_en = 1'b1;
            end
            default: ;
        endcase
    end

    // Operand selection for the shared multiplier and the rotator.
    always_comb
    begin
        op_a    = '0;
        op_b    = '0;
        c_start = 1'b0;
        c_a0    = cur_x_reg;
        c_b0    = cur_y_reg;
        c_angle = prod[55:24];
        unique case (state_reg)
            T_AX0:
            begin
                op_a = MA_W'(field_x_reg);
                op_b = period_op;
            end
            T_AX1, T_K4:
            begin
                op_a = prod_sh24[MA_W-1:0];
                op_b = angle_k_op;
            end
            T_K0:
            begin
                op_a = MA_W'(coupling_reg);
                op_b = MB_W'(prev_z_reg);
            end
            T_K1:
            begin
                op_a = MA_W'(coupling_reg);
                op_b = MB_W'(nz_reg);
            end
            T_K3:
            begin
                op_a = MA_W'(kappa_reg);
                op_b = period_op;
            end
            T_K5:
            begin
                c_start = 1'b1;
            end
            T_C1, T_C2:
            begin
                op_a = MA_W'(c_a);
                op_b = comp_op;
            end
            T_G1, T_G3:
            begin
                op_a = MA_W'(c_b);
                op_b = comp_op;
            end
            T_G2:
            begin
                c_start = 1'b1;
                c_a0    = prod_sat;
                c_b0    = cur_z_reg;
                c_angle = ax_reg;
            end
            E_M0:
            begin
                op_a = MA_W'(cur_z_reg);
                op_b = MB_W'(rd_z);
            end
            E_M1:
            begin
                op_a = prod_sh30[MA_W-1:0];
                op_b = MB_W'(coupling_reg);
            end
            E_M2:
            begin
                op_a = MA_W'(field_z_reg);
                op_b = MB_W'(cur_z_reg);
            end
            E_M3:
            begin
                op_a = MA_W'(field_x_reg);
                op_b = MB_W'(cur_x_reg);
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_acc && (s_tuser == MODE_STEP))
                begin
                    state_next = T_AX0;
                end
                else if (s_acc && (s_tuser == MODE_READ))
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            T_AX0: state_next = T_AX1;
            T_AX1: state_next = T_AX2;
            T_AX2: state_next = T_RC;
            T_RC:  state_next = T_RN;
            T_RN:  state_next = T_K0;
            T_K0:  state_next = T_K1;
            T_K1:  state_next = T_K2;
            T_K2:  state_next = T_K3;
            T_K3:  state_next = T_K4;
            T_K4:  state_next = T_K5;
            T_K5:  state_next = T_C1;
            T_C1:
            begin
                if (c_stat.done)
                begin
                    state_next = T_G1;
                end
            end
            T_G1:  state_next = T_G2;
            T_G2:  state_next = T_C2;
            T_C2:
            begin
                if (c_stat.done)
                begin
                    state_next = T_G3;
                end
            end
            T_G3:  state_next = T_G4;
            T_G4:  state_next = has_next ? T_RC : E_RC;
            E_RC:  state_next = E_RN;
            E_RN:  state_next = E_M0;
            E_M0:  state_next = E_M1;
            E_M1:  state_next = E_M2;
            E_M2:  state_next = E_M3;
            E_M3:  state_next = E_M4;
            E_M4:  state_next = has_next ? E_RC : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            j_reg        <= '0;
            n_reg        <= NW'(2);
            kind_reg     <= KIND_ENERGY;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (s_acc)
            begin
                n_reg    <= ring_n;
                kind_reg <= (s_tuser == MODE_READ) ? KIND_SPIN : KIND_ENERGY;
            end
            if (state_reg == T_AX2)
            begin
                j_reg <= '0;
            end
            else if ((state_reg == T_G4) || (state_reg == E_M4))
            begin
                j_reg <= has_next ? nxt_j : '0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            T_AX1: first_z_reg <= rd_z;
            T_AX2:
            begin
                prev_z_reg <= rd_z;
                ax_reg     <= prod[55:24];
            end
            T_RN, E_RN:
            begin
                cur_x_reg <= rd_x;
                cur_y_reg <= rd_y;
                cur_z_reg <= rd_z;
            end
            T_K0: nz_reg <= has_next ? rd_z : first_z_reg;
            T_K1: kacc_reg <= prod_sh30[34:0];
            T_K2: kappa_reg <= sat32(MP_W'(ksum));
            T_G1: new_x_reg <= prod_sat;
            T_G3: new_y_reg <= prod_sat;
            T_G4:
            begin
                prev_z_reg <= cur_z_reg;
                if (!has_next)
                begin
                    acc_reg <= '0;
                end
            end
            E_M2, E_M3, E_M4: acc_reg <= acc_reg + prod_sh24[ACC_W-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tuser_reg <= kind_reg;
            if (kind_reg == KIND_SPIN)
            begin
                m_tdata_reg <= {rd_z, rd_y, rd_x, 48'd0};
            end
            else
            begin
                m_tdata_reg <= {96'd0, sat48(acc_half)};
            end
        end
    end

endmodule

// File: rtl/core/dscps_check.sv
`timescale 1ns / 1ps
// Port-level checker for the driven spin chain block, bound to the top level.
// Depends on dscps_pkg for widths and result kinds.
module dscps_check
    import dscps_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [1:0]          s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [0:0]          m_tuser
);

    // A held result word keeps its contents until taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // A step or read word keeps the input closed in the following cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == MODE_STEP || s_tuser == MODE_READ)
        |=> !s_tready)
        else $error("input open right after a step or read word");

    a_energy_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[0] == KIND_ENERGY) |-> m_tdata[M_DATA_W-1:48] == '0)
        else $error("energy word carries spin data");

    a_spin_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[0] == KIND_SPIN) |-> m_tdata[47:0] == '0)
        else $error("spin word carries energy data");

endmodule

bind driven_spin_chain_period_step dscps_check u_dscps_check (.*);

// File: tb/driven_spin_chain_period_step_tb.sv
`timescale 1ns / 1ps
// Testbench for driven_spin_chain_period_step: loads, reads and period steps of the spin ring,
// checked word by word against a predictor of the ring kept in the bench.
// Depends on dscps_pkg and the RTL of the block.
module driven_spin_chain_period_step_tb;
    import dscps_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [1:0]         mode;
        logic [6:0]         idx;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } spin_word_t;

    typedef struct {
        logic               kind;
        logic signed [47:0] energy;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } ring_result_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [1:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic [0:0]          m_tuser;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [2:0]          cfg_index;
    logic [31:0]         cfg_data;

    driven_spin_chain_period_step DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predicted state of the ring.
    logic signed [31:0] ring_x [MAX_SPINS];
    logic signed [31:0] ring_y [MAX_SPINS];
    logic signed [31:0] ring_z [MAX_SPINS];
    longint             coup_j;
    longint             fld_h;
    longint             fld_g;
    longint             per_t;
    int                 chain_reg;
    logic [31:0]        gain_c;

    spin_word_t   word_q [$];
    ring_result_t ring_exp_q [$];
    spin_word_t   cur_word;

    // Generator view of which spins hold loaded values.
    bit gen_loaded [MAX_SPINS];
    int gen_ring;

    int snd_idle_pct;
    int rcv_stall_pct;
    int hold_gen;
    int hold_seen;
    int hold_cnt;
    int mismatches;
    int energies_seen;
    int spins_seen;
    int loads_sent;
    int wd_cnt;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint sat_bits(input longint v, input int bits);
        longint hi;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    function automatic logic [31:0] cordic_gain_comp();
        longint unsigned k;
        longint unsigned c;
        longint unsigned t;
        k = 64'd1 << 60;
        c = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            k += k >> (2 * i);
        end
        k = k >> 30;
        for (int b = 30; b >= 0; b--)
        begin
            t = c | (64'd1 << b);
            if (((t * t) >> 31) * k <= (64'd1 << 61))
                c = t;
        end
        return c[31:0];
    endfunction

    // Rate in Q8.24 times the period gives the half-period turn in 2^-32 turn units.
    function automatic logic [31:0] half_turn(input longint rate);
        longint            p;
        longint unsigned   u;
        p = (rate * per_t) >>> 24;
        u = longint'(p) * 64'd341782638;
        return u[55:24];
    endfunction

    task automatic cordic_turn(inout logic signed [31:0] pa, inout logic signed [31:0] pb,
                               input logic [31:0] ang);
        longint      a;
        longint      b;
        longint      r;
        longint      da;
        longint      db;
        logic [31:0] t;
        a = pa;
        b = pb;
        t = ang;
        if ((t + 32'h4000_0000) & 32'h8000_0000)
        begin
            a = -a;
            b = -b;
            t = t + 32'h8000_0000;
        end
        r = longint'($signed(t));
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            da = b >>> i;
            db = a >>> i;
            if (r >= 0)
            begin
                a -= da;
                b += db;
                r -= longint'(ATAN_TURNS[i]);
            end
            else
            begin
                a += da;
                b -= db;
                r += longint'(ATAN_TURNS[i]);
            end
        end
        pa = 32'(sat_bits((a * longint'(gain_c)) >>> 31, 32));
        pb = 32'(sat_bits((b * longint'(gain_c)) >>> 31, 32));
    endtask

    function automatic int ring_len();
        if (chain_reg < 2)
            return 2;
        if (chain_reg > MAX_SPINS)
            return MAX_SPINS;
        return chain_reg;
    endfunction

    task automatic advance_ring(output logic signed [47:0] energy);
        int          n;
        longint      first_z;
        longint      prev_z;
        longint      old_z;
        longint      next_z;
        longint      kappa;
        longint      zz;
        longint      total;
        logic [31:0] ax;
        int          nx;
        n = ring_len();
        ax = half_turn(fld_g);
        first_z = ring_z[0];
        prev_z = ring_z[n - 1];
        total = 0;
        for (int j = 0; j < n; j++)
        begin
            old_z = ring_z[j];
            next_z = (j + 1 < n) ? longint'(ring_z[j + 1]) : first_z;
            kappa = ((coup_j * prev_z) >>> 30) + ((coup_j * next_z) >>> 30) + fld_h;
            kappa = sat_bits(kappa, 32);
            cordic_turn(ring_x[j], ring_y[j], half_turn(kappa));
            cordic_turn(ring_y[j], ring_z[j], ax);
            prev_z = old_z;
        end
        for (int j = 0; j < n; j++)
        begin
            nx = (j + 1 < n) ? j + 1 : 0;
            zz = (longint'(ring_z[j]) * longint'(ring_z[nx])) >>> 30;
            total += (coup_j * zz) >>> 24;
            total += (fld_h * longint'(ring_z[j])) >>> 24;
            total += (fld_g * longint'(ring_x[j])) >>> 24;
        end
        energy = 48'(sat_bits(total >>> 1, 48));
    endtask

    task automatic predict_word(input spin_word_t w);
        ring_result_t r;
        r = '{kind: KIND_ENERGY, energy: '0, x: '0, y: '0, z: '0};
        case (w.mode)
            MODE_LOAD:
            begin
                ring_x[w.idx] = w.x;
                ring_y[w.idx] = w.y;
                ring_z[w.idx] = w.z;
            end
            MODE_STEP:
            begin
                advance_ring(r.energy);
                ring_exp_q = {ring_exp_q, r};
            end
            MODE_READ:
            begin
                r.kind = KIND_SPIN;
                r.x = ring_x[w.idx];
                r.y = ring_y[w.idx];
                r.z = ring_z[w.idx];
                ring_exp_q = {ring_exp_q, r};
            end
            default: ;
        endcase
    endtask

    task automatic apply_reg(input logic [2:0] idx, input logic [31:0] val);
        case (idx)
            REG_COUPLING: coup_j = longint'($signed(val));
            REG_FIELD_Z:  fld_h = longint'($signed(val));
            REG_FIELD_X:  fld_g = longint'($signed(val));
            REG_PERIOD:   per_t = longint'(val[30:0]);
            REG_CHAIN:    chain_reg = int'(val[7:0]);
            default: ;
        endcase
    endtask

    // Sender side.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= MODE_LOAD;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
                predict_word(cur_word);
            if (word_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct)
            begin
                cur_word = word_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= cur_word.mode;
                s_tdata  <= {1'b0, cur_word.z, cur_word.y, cur_word.x, cur_word.idx};
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver side and result check.
    always @(posedge clk or negedge rst_n)
    begin
        ring_result_t e;
        ring_result_t got;
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_cnt  = 0;
            hold_seen = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.kind   = m_tuser[0];
                got.energy = m_tdata[47:0];
                got.x      = m_tdata[79:48];
                got.y      = m_tdata[111:80];
                got.z      = m_tdata[143:112];
                if (ring_exp_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR %0t: result with none expected, kind %0d energy %0d",
                                 $realtime, got.kind, got.energy);
                end
                else
                begin
                    e = ring_exp_q.pop_front();
                    if (e.kind == KIND_ENERGY)
                        energies_seen++;
                    else
                        spins_seen++;
                    if (got.kind !== e.kind || got.energy !== e.energy || got.x !== e.x
                        || got.y !== e.y || got.z !== e.z)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("ERROR %0t: expected kind %0d energy %0d xyz %0d %0d %0d",
                                     $realtime, e.kind, e.energy, e.x, e.y, e.z);
                            $display("        actual   kind %0d energy %0d xyz %0d %0d %0d",
                                     got.kind, got.energy, got.x, got.y, got.z);
                        end
                    end
                end
            end
            if (hold_seen != hold_gen)
            begin
                hold_seen = hold_gen;
                hold_cnt  = HOLD_CYCLES;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
            end
        end
    end

    // Any accepted word, result or register write resets the watchdog.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            wd_cnt <= 0;
        else
            wd_cnt <= wd_cnt + 1;
        if (wd_cnt >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired with %0d results outstanding", ring_exp_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic push_word(input logic [1:0] mode, input logic [6:0] idx,
                             input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        spin_word_t w;
        w = '{mode: mode, idx: idx, x: x, y: y, z: z};
        if (mode == MODE_LOAD)
        begin
            gen_loaded[idx] = 1'b1;
            loads_sent++;
        end
        word_q = {word_q, w};
    endtask

    function automatic logic [31:0] rand_comp();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
    endfunction

    function automatic logic [6:0] pick_loaded();
        int s;
        s = $urandom_range(0, MAX_SPINS - 1);
        for (int k = 0; k < MAX_SPINS; k++)
        begin
            if (gen_loaded[(s + k) % MAX_SPINS])
                return 7'((s + k) % MAX_SPINS);
        end
        return 7'd0;
    endfunction

    // Random mix: loads, reads of loaded spins, steps over a fully loaded ring, and noise.
    task automatic push_random();
        int r;
        int top;
        r = $urandom_range(0, 99);
        top = (gen_ring + 3 > MAX_SPINS - 1) ? MAX_SPINS - 1 : gen_ring + 3;
        if (r < 10)
        begin
            push_word(MODE_SPARE, 7'($urandom), $urandom, $urandom, $urandom);
        end
        else if (r < 45)
        begin
            push_word(MODE_LOAD, 7'($urandom_range(0, top)), rand_comp(), rand_comp(),
                      rand_comp());
        end
        else if (r < 75)
        begin
            push_word(MODE_READ, pick_loaded(), $urandom, $urandom, $urandom);
        end
        else
        begin
            for (int j = 0; j < gen_ring; j++)
            begin
                if (!gen_loaded[j])
                    push_word(MODE_LOAD, 7'(j), rand_comp(), rand_comp(), rand_comp());
            end
            push_word(MODE_STEP, 7'($urandom), $urandom, $urandom, $urandom);
        end
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (word_q.size() != 0 || s_tvalid || ring_exp_q.size() != 0);
        // A trailing load has no result, so give it time to land.
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(idx, val);
        cfg_valid <= 1'b0;
        if (idx == REG_CHAIN)
            gen_ring = (val[7:0] < 2) ? 2 : (val[7:0] > MAX_SPINS) ? MAX_SPINS : val[7:0];
    endtask

    task automatic random_phase(input int snd, input int rcv, input int count);
        snd_idle_pct  = snd;
        rcv_stall_pct = rcv;
        for (int i = 0; i < count; i++)
            push_random();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_COUPLING;
        cfg_data      = '0;
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        hold_gen      = 0;
        mismatches    = 0;
        energies_seen = 0;
        spins_seen    = 0;
        loads_sent    = 0;
        wd_cnt        = 0;
        gain_c        = cordic_gain_comp();
        coup_j        = 16777216;
        fld_h         = 11819745;
        fld_g         = 13572571;
        per_t         = 27750626;
        chain_reg     = 100;
        gen_ring      = 100;
        for (int i = 0; i < MAX_SPINS; i++)
        begin
            gen_loaded[i] = 1'b0;
            ring_x[i] = '0;
            ring_y[i] = '0;
            ring_z[i] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: chain length below range clamps to two, extreme spins, reads outside
        // the ring, the spare mode, and steps from reset register values.
        write_reg(REG_CHAIN, 32'd0);
        push_word(MODE_LOAD, 7'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        push_word(MODE_LOAD, 7'd1, 32'h0, 32'h0, 32'h4000_0000);
        push_word(MODE_LOAD, 7'd127, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_word(MODE_READ, 7'd0, 32'h0, 32'h0, 32'h0);
        push_word(MODE_READ, 7'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_word(MODE_READ, 7'd127, 32'h0, 32'h0, 32'h0);
        push_word(MODE_SPARE, 7'd5, 32'h1234_5678, 32'h0, 32'h0);
        push_word(MODE_STEP, 7'd0, 32'h0, 32'h0, 32'h0);
        push_word(MODE_READ, 7'd0, 32'h0, 32'h0, 32'h0);
        push_word(MODE_READ, 7'd1, 32'h0, 32'h0, 32'h0);
        push_word(MODE_STEP, 7'd0, 32'h0, 32'h0, 32'h0);
        push_word(MODE_LOAD, 7'd1, 32'h4000_0000, 32'h0, 32'h0);
        push_word(MODE_STEP, 7'd0, 32'h0, 32'h0, 32'h0);
        push_word(MODE_READ, 7'd1, 32'h0, 32'h0, 32'h0);
        drain();

        // Mid-range random registers, short ring, no idling.
        write_reg(REG_CHAIN, 32'd8);
        write_reg(REG_COUPLING, $urandom_range(0, 32'h0400_0000) - 32'h0200_0000);
        write_reg(REG_FIELD_Z, $urandom_range(0, 32'h0400_0000) - 32'h0200_0000);
        write_reg(REG_FIELD_X, $urandom_range(0, 32'h0400_0000) - 32'h0200_0000);
        write_reg(REG_PERIOD, $urandom_range(0, 32'h0800_0000));
        random_phase(0, 0, 18);
        drain();

        // Register extremes on a twelve-spin ring, with the receiver held off for a long
        // stretch.
        write_reg(REG_CHAIN, 32'd12);
        write_reg(REG_COUPLING, 32'h8000_0000);
        write_reg(REG_FIELD_Z, 32'h7FFF_FFFF);
        write_reg(REG_FIELD_X, 32'h8000_0000);
        write_reg(REG_PERIOD, 32'h7FFF_FFFF);
        hold_gen++;
        random_phase(0, 62, 9);
        drain();
        random_phase(0, 62, 9);
        drain();

        // Zero registers and the shortest ring, sender idling.
        write_reg(REG_CHAIN, 32'd1);
        write_reg(REG_COUPLING, 32'h0);
        write_reg(REG_FIELD_Z, 32'h0);
        write_reg(REG_FIELD_X, 32'h0);
        write_reg(REG_PERIOD, 32'h0);
        random_phase(62, 0, 18);
        drain();

        // Default-like setting on a longer ring, both sides idling.
        write_reg(REG_CHAIN, 32'd16);
        write_reg(REG_COUPLING, 32'h0100_0000);
        write_reg(REG_FIELD_Z, 32'h00B4_5A61);
        write_reg(REG_FIELD_X, 32'h00CF_19DB);
        write_reg(REG_PERIOD, 32'h01A7_70E2);
        random_phase(17, 17, 18);
        drain();
        repeat (50) @(posedge clk);

        $display("Covered %0d spin loads, %0d readbacks and %0d period steps",
                 loads_sent, spins_seen, energies_seen);
        $display("over ring lengths 2 to 16 with register extremes and stalls; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && ring_exp_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
